// ===== rtl/sobel_edge_magnitude_3x3_defines.svh =====
// Assertion macros shared by the Sobel edge block.
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SEM_ASSERT_IMP(lbl, c, a, e) \
  lbl: assert property (@(posedge c) disable iff (e) (a)) else $error("check failed");
`define SEM_ASSERT_NXT(lbl, c, a, b, e) \
  lbl: assert property (@(posedge c) disable iff (e) (a) |=> (b)) else $error("check failed");
`else
`define SEM_ASSERT_IMP(lbl, c, a, e)
`define SEM_ASSERT_NXT(lbl, c, a, b, e)
`endif
`endif

// ===== rtl/sem_pkg.sv =====
// Types and constants shared by the Sobel edge block.
package sem_pkg;
  localparam int PIX_W = 24;
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;
  localparam logic [7:0] EDGE_MAX = 8'd255;
  localparam logic [16:0] SAT_LIMIT = 17'd65281;

  // One masked window and its frame-end flag, as handed to the back end.
  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic last;
  } win_item_t;

  // Saturated sum of squares of the masked Sobel gradients of one channel.
  function automatic logic [16:0] sum_sq(input logic [8:0][7:0] p);
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic signed [21:0] gx2;
    logic signed [21:0] gy2;
    logic [21:0] s;
    gx = ($signed({4'd0, p[2]}) + $signed({3'd0, p[5], 1'b0}) + $signed({4'd0, p[8]}))
       - ($signed({4'd0, p[0]}) + $signed({3'd0, p[3], 1'b0}) + $signed({4'd0, p[6]}));
    gy = ($signed({4'd0, p[6]}) + $signed({3'd0, p[7], 1'b0}) + $signed({4'd0, p[8]}))
       - ($signed({4'd0, p[0]}) + $signed({3'd0, p[1], 1'b0}) + $signed({4'd0, p[2]}));
    gx2 = gx * gx;
    gy2 = gy * gy;
    s = $unsigned(gx2 + gy2);
    sum_sq = (s >= 22'(SAT_LIMIT)) ? SAT_LIMIT : s[16:0];
  endfunction
endpackage

// ===== rtl/sem_front.sv =====
// Front end: counters, line stores, window and border masking.
module sem_front
  import sem_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic operation,
  input  logic [PIX_W-1:0] pixel,
  input  logic cfg_hit,
  input  logic [10:0] width_eff,
  input  logic [15:0] height_eff,
  output logic q_valid,
  input  logic q_full,
  output win_item_t q_item
);
  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int CNTW = CW + 1;

  logic [PIX_W-1:0] upper_mem [MAX_LINE_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_LINE_WIDTH];
  logic [8:0][PIX_W-1:0] win;
  logic [CNTW-1:0] in_col, out_col;
  logic [16:0] in_row;
  logic [15:0] out_row;
  logic [CNTW-1:0] wlim;
  logic drain, take, emit, last, col_wrap, ocol_wrap, restart;
  logic [CW-1:0] col, col_next;
  logic [PIX_W-1:0] pix, above, mid;
  logic [8:0][PIX_W-1:0] win_next;

  assign wlim = (int'(width_eff) > MAX_LINE_WIDTH) ? CNTW'(MAX_LINE_WIDTH) : CNTW'(width_eff);
  assign drain = (in_row >= {1'b0, height_eff});
  assign in_stall = q_full;
  assign take = in_valid && !q_full && (drain || operation == OP_PIXEL);
  assign pix = drain ? '0 : pixel;
  assign col = in_col[CW-1:0];
  assign restart = rst || cfg_hit || (q_valid && last);

  // Column that the next item will use.
  always_comb begin
    if (restart || (take && col_wrap)) col_next = '0;
    else if (take) col_next = col + CW'(1);
    else col_next = col;
  end

  // Line stores: one write per item, and a registered read of the next item's column.
  always_ff @(posedge clk) begin
    if (take) begin
      upper_mem[col] <= mid;
      middle_mem[col] <= pix;
    end
    if (take && col_next == col) begin
      above <= mid;
      mid <= pix;
    end else begin
      above <= upper_mem[col_next];
      mid <= middle_mem[col_next];
    end
  end

  always_comb begin
    win_next = win;
    for (int r = 0; r < 3; r++) begin
      win_next[r*3] = win[r*3+1];
      win_next[r*3+1] = win[r*3+2];
    end
    win_next[2] = above;
    win_next[5] = mid;
    win_next[8] = pix;
  end

  assign emit = (in_row >= 17'd2) || (in_row == 17'd1 && in_col != '0);
  assign col_wrap = (in_col + 1'b1) >= wlim;
  assign ocol_wrap = (out_col + 1'b1) >= wlim;
  assign last = (out_row == height_eff - 16'd1) && (out_col == wlim - 1'b1);

  // Masked window for the result of this item.
  always_comb begin
    q_item.last = last;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        q_item.win[r*3+c] = ((r == 0 && out_row == 16'd0)
          || (r == 2 && out_row == height_eff - 16'd1)
          || (c == 0 && out_col == '0)
          || (c == 2 && out_col == wlim - 1'b1)) ? '0 : win_next[r*3+c];
      end
    end
  end
  assign q_valid = take && emit;

  always_ff @(posedge clk) begin
    if (restart) begin
      win <= '0;
      in_col <= '0;
      in_row <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (take) begin
      win <= win_next;
      in_col <= col_wrap ? '0 : in_col + 1'b1;
      in_row <= col_wrap ? in_row + 17'd1 : in_row;
      if (emit) begin
        out_col <= ocol_wrap ? '0 : out_col + 1'b1;
        out_row <= ocol_wrap ? out_row + 16'd1 : out_row;
      end
    end
  end
endmodule

// ===== rtl/sem_back.sv =====
// Back end: item queue, gradient sums and rounded integer root per channel.
module sem_back
  import sem_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_full,
  input  win_item_t q_item,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] red_edge,
  output logic [7:0] green_edge,
  output logic [7:0] blue_edge,
  output logic frame_end,
  output logic busy
);
  `include "sobel_edge_magnitude_3x3_defines.svh"
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_OUT = 2'd3;

  // Two-entry queue between the front and back ends.
  win_item_t fifo [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic pop;
  logic [1:0] state;
  logic [2:0][16:0] s;
  logic [2:0][16:0] rem;
  logic [2:0][8:0] res;
  logic [3:0] step;
  logic lastr;
  logic [8:0][7:0] pr, pg, pb;
  logic [2:0][7:0] rnd;

  assign q_full = cnt == 2'd2;
  assign pop = state == ST_IDLE && cnt != 2'd0;

  always_ff @(posedge clk) begin
    if (q_valid && !q_full) fifo[wp] <= q_item;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (q_valid && !q_full) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(q_valid && !q_full) - 2'(pop);
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pr[i] = fifo[rp].win[i][23:16];
      pg[i] = fifo[rp].win[i][15:8];
      pb[i] = fifo[rp].win[i][7:0];
    end
  end

  // Rounding: saturated sums give EDGE_MAX; else bump the floor root when s exceeds n*n + n, which is rem > n.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = (s[k] >= SAT_LIMIT) ? EDGE_MAX
        : ((17'(rem[k]) > 17'(res[k])) ? 8'(res[k] + 9'd1) : res[k][7:0]);
    end
  end

  // One bit pair of the restoring root per cycle, eight steps over the low 16 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (pop) begin
          s[0] <= sum_sq(pr);
          s[1] <= sum_sq(pg);
          s[2] <= sum_sq(pb);
          lastr <= fifo[rp].last;
          state <= ST_SUM;
        end
        ST_SUM: begin
          for (int k = 0; k < 3; k++) begin
            rem[k] <= '0;
            res[k] <= '0;
          end
          step <= 4'd7;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          for (int k = 0; k < 3; k++) begin
            logic [18:0] trial;
            logic [18:0] r2;
            r2 = {rem[k], s[k][2*step +: 2]};
            trial = {8'd0, res[k], 2'b01};
            if (r2 >= trial) begin
              rem[k] <= 17'(r2 - trial);
              res[k] <= {res[k][7:0], 1'b1};
            end else begin
              rem[k] <= 17'(r2);
              res[k] <= {res[k][7:0], 1'b0};
            end
          end
          if (step == 4'd0) state <= ST_OUT;
          else step <= step - 4'd1;
        end
        ST_OUT: begin
          if (!out_valid) begin
            red_edge <= rnd[0];
            green_edge <= rnd[1];
            blue_edge <= rnd[2];
            frame_end <= lastr;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (out_valid && !out_stall && !(state == ST_OUT)) out_valid <= 1'b0;
      else if (out_valid && !out_stall && state == ST_OUT) out_valid <= 1'b0;
    end
  end

  assign busy = cnt != 2'd0 || state != ST_IDLE || out_valid;

  `SEM_ASSERT_IMP(a_cnt_range, clk, cnt != 2'd3, rst)
  `SEM_ASSERT_NXT(a_pop_leaves_idle, clk, pop, state == ST_SUM, rst)
  `SEM_ASSERT_NXT(a_hold_out, clk, out_valid && out_stall, out_valid && $stable(red_edge), rst)
endmodule

// ===== rtl/sobel_edge_magnitude_3x3.sv =====
// Sobel edge magnitude 3x3 block: front end, queue and root back end.
// Each result holds the back end while it is taken from the queue and its sums of
// squares are formed, while the root is cleared, for eight steps of the integer
// square root shared by the three channels and until the output register is loaded.
// Items that give no result do not enter the queue. A two-entry queue lets the front
// accept items while a root runs. The result of a pixel appears W + 1 pixel or drain
// items after it, W being frame_width held to 2..MAX_LINE_WIDTH; flush items drain the
// last row, and the final result of a frame carries frame_end. Register writes are
// taken only once every result has left the block.
module sobel_edge_magnitude_3x3
  import sem_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic operation,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] red_edge,
  output logic [7:0] green_edge,
  output logic [7:0] blue_edge,
  output logic frame_end,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [15:0] cfg_data
);
  logic [10:0] frame_width;
  logic [15:0] frame_height;
  logic [10:0] width_eff;
  logic [15:0] height_eff;
  logic q_valid, q_full, busy, cfg_hit;
  win_item_t q_item;

  assign cfg_ready = !busy;
  assign cfg_hit = cfg_valid && cfg_ready;
  assign width_eff = (frame_width < 11'd2) ? 11'd2 : frame_width;
  assign height_eff = (frame_height < 16'd2) ? 16'd2 : frame_height;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 11'd640;
      frame_height <= 16'd480;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        CFG_WIDTH: frame_width <= cfg_data[10:0];
        CFG_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  sem_front #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .operation,
    .pixel({red_in, green_in, blue_in}), .cfg_hit, .width_eff, .height_eff,
    .q_valid, .q_full, .q_item
  );

  sem_back u_back (
    .clk, .rst, .q_valid, .q_full, .q_item, .out_valid, .out_stall,
    .red_edge, .green_edge, .blue_edge, .frame_end, .busy
  );
endmodule
